### rtl/wrte_pkg.sv
// Shared types and codes for the window record table.
// Used by wrte_ctrl, wrte_datapath and window_record_table_evict_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wrte_pkg;

    localparam logic [2:0] OP_GET          = 3'd0;
    localparam logic [2:0] OP_FIND         = 3'd1;
    localparam logic [2:0] OP_MARK_BEGUN   = 3'd2;
    localparam logic [2:0] OP_SET_VIEWPORT = 3'd3;
    localparam logic [2:0] OP_SET_OPEN     = 3'd4;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_APPENDED  = 3'd1;
    localparam logic [2:0] ST_RECLAIMED = 3'd2;
    localparam logic [2:0] ST_SCRATCH   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_UPDATED   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOKUP,
        S_EVICT,
        S_WRITE,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       scan_clear;
        logic       scan_run;
        logic       scan_evict;
        logic       sel_append;
        logic       wr_en;
        logic       wr_create;
        logic       set_res;
        logic [2:0] res_code;
        logic       resp_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       key_zero;
        logic       scan_done;
        logic       hit;
        logic       victim;
        logic       below_limit;
    } stat_t;

endpackage

`default_nettype wire

### rtl/wrte_ctrl.sv
// Sequencer for the window record table: decode, lookup scan, reclaim scan, write, response.
// Depends on wrte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrte_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           out_free,
    input  wire wrte_pkg::stat_t stat,
    output wrte_pkg::cmd_t      cmd
);
    import wrte_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if ((stat.op > OP_SET_OPEN) || ((stat.op != OP_GET) && stat.key_zero))
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.set_res = 1'b1;
                    if (stat.hit)
                    begin
                        if ((stat.op == OP_GET) || (stat.op == OP_FIND))
                        begin
                            cmd.res_code = ST_FOUND;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            cmd.res_code = ST_UPDATED;
                            state_next   = S_WRITE;
                        end
                    end
                    else if (stat.op != OP_GET)
                    begin
                        cmd.res_code = ST_NOT_FOUND;
                        state_next   = S_RESP;
                    end
                    else if (stat.below_limit)
                    begin
                        cmd.sel_append = 1'b1;
                        cmd.res_code   = ST_APPENDED;
                        state_next     = S_WRITE;
                    end
                    else
                    begin
                        // no result yet: start the reclaim pass
                        cmd.set_res    = 1'b0;
                        cmd.scan_clear = 1'b1;
                        cmd.scan_evict = 1'b1;
                        state_next     = S_EVICT;
                    end
                end
            end
            S_EVICT:
            begin
                cmd.scan_run   = 1'b1;
                cmd.scan_evict = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.set_res = 1'b1;
                    if (stat.victim)
                    begin
                        cmd.res_code = ST_RECLAIMED;
                        state_next   = S_WRITE;
                    end
                    else
                    begin
                        cmd.res_code = ST_SCRATCH;
                        state_next   = S_RESP;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_create = (stat.op == OP_GET);
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ap_resp_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_load |-> out_free)
        else $error("response loaded while output register occupied");

    ap_write_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ($past(state_reg) == S_LOOKUP || $past(state_reg) == S_EVICT))
        else $error("table write without a preceding scan");

    ap_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in progress");

endmodule

`default_nettype wire

### rtl/wrte_datapath.sv
// Datapath of the window record table: entry memory, scan pipeline, limit, result fields.
// Depends on wrte_pkg; driven by wrte_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module wrte_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CNT_W-1:0]     cfg_wr_data,
    input  wire logic [2:0]           opcode,
    input  wire logic [KEY_BITS-1:0]  window_key,
    input  wire logic [31:0]          current_frame,
    input  wire logic [7:0]           viewport_index,
    input  wire logic                 open_request,
    input  wire wrte_pkg::cmd_t       cmd,
    output wrte_pkg::stat_t           stat,
    output logic [CNT_W-1:0]          res_slot,
    output logic [2:0]                res_status,
    output logic [7:0]                res_viewport,
    output logic                      res_open
);
    import wrte_pkg::*;

    // entry memory
    logic [KEY_BITS-1:0] key_mem    [TABLE_DEPTH];
    logic [31:0]         frame_mem  [TABLE_DEPTH];
    logic [7:0]          vp_mem     [TABLE_DEPTH];
    logic                closed_mem [TABLE_DEPTH];

    logic [KEY_BITS-1:0] rd_key_reg;
    logic [31:0]         rd_frame_reg;
    logic [7:0]          rd_vp_reg;
    logic                rd_closed_reg;

    // captured transaction
    logic [2:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [31:0]         frame_reg;
    logic [7:0]          vp_reg;
    logic                open_reg;

    logic [CNT_W-1:0]    limit_cfg_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;
    logic [CNT_W-1:0]    limit_eff;

    logic [CNT_W-1:0]    scan_idx_reg;
    logic [CNT_W-1:0]    scan_idx_next;
    logic                pend_reg;
    logic                pend_next;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                hit_reg;
    logic                hit_next;
    logic                victim_reg;
    logic                victim_next;
    logic [31:0]         oldest_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [7:0]          hit_vp_reg;
    logic [31:0]         hit_frame_reg;
    logic                hit_closed_reg;
    logic [2:0]          res_code_reg;

    logic                scan_more;
    logic                issue;
    logic                match;
    logic                take;

    logic [31:0]         wr_frame;
    logic [7:0]          wr_vp;
    logic                wr_closed;

    always_comb
    begin
        if (limit_cfg_reg == '0)
        begin
            limit_eff = CNT_W'(1);
        end
        else if (limit_cfg_reg > CNT_W'(TABLE_DEPTH))
        begin
            limit_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            limit_eff = limit_cfg_reg;
        end
    end

    // scan: one read issued per cycle, compared in the following cycle on the registered data
    always_comb
    begin
        scan_more = (scan_idx_reg < used_reg);
        match = cmd.scan_run && !cmd.scan_evict && pend_reg && !hit_reg
                && (rd_key_reg == key_reg);
        take  = cmd.scan_run && cmd.scan_evict && pend_reg
                && (rd_frame_reg != frame_reg) && (rd_vp_reg == 8'd0)
                && (!victim_reg || (rd_frame_reg < oldest_reg));
        issue = cmd.scan_run && scan_more
                && (cmd.scan_evict || !(hit_reg || match));

        scan_idx_next = scan_idx_reg;
        pend_next     = issue;
        hit_next      = hit_reg || match;
        victim_next   = victim_reg || take;
        if (issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
        if (cmd.scan_clear)
        begin
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
            victim_next   = 1'b0;
        end

        used_next = used_reg;
        if (cmd.sel_append)
        begin
            used_next = used_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.key_zero    = (key_reg == '0);
        stat.scan_done   = hit_reg || (!pend_reg && !scan_more);
        stat.hit         = hit_reg;
        stat.victim      = victim_reg;
        stat.below_limit = (used_reg < limit_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg <= CNT_W'(TABLE_DEPTH);
            used_reg      <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            victim_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_cfg_reg <= cfg_wr_data;
            end
            used_reg     <= used_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            victim_reg   <= victim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= opcode;
            key_reg   <= window_key;
            frame_reg <= current_frame;
            vp_reg    <= viewport_index;
            open_reg  <= open_request;
        end
        if (issue)
        begin
            pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (match)
        begin
            slot_reg       <= pend_idx_reg;
            hit_vp_reg     <= rd_vp_reg;
            hit_frame_reg  <= rd_frame_reg;
            hit_closed_reg <= rd_closed_reg;
        end
        else if (take)
        begin
            slot_reg   <= pend_idx_reg;
            oldest_reg <= rd_frame_reg;
        end
        else if (cmd.sel_append)
        begin
            slot_reg <= used_reg[IDX_W-1:0];
        end
        if (cmd.set_res)
        begin
            res_code_reg <= cmd.res_code;
        end
    end

    // record written back: fresh entry, or the hit entry with one field changed
    always_comb
    begin
        wr_frame  = hit_frame_reg;
        wr_vp     = hit_vp_reg;
        wr_closed = hit_closed_reg;
        if (cmd.wr_create)
        begin
            wr_frame  = 32'd0;
            wr_vp     = vp_reg;
            wr_closed = 1'b0;
        end
        else if (op_reg == OP_MARK_BEGUN)
        begin
            wr_frame = frame_reg;
        end
        else if (op_reg == OP_SET_VIEWPORT)
        begin
            wr_vp = vp_reg;
        end
        else if (op_reg == OP_SET_OPEN)
        begin
            wr_closed = !open_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[slot_reg]    <= key_reg;
            frame_mem[slot_reg]  <= wr_frame;
            vp_mem[slot_reg]     <= wr_vp;
            closed_mem[slot_reg] <= wr_closed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_key_reg    <= key_mem[scan_idx_reg[IDX_W-1:0]];
            rd_frame_reg  <= frame_mem[scan_idx_reg[IDX_W-1:0]];
            rd_vp_reg     <= vp_mem[scan_idx_reg[IDX_W-1:0]];
            rd_closed_reg <= closed_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        res_status   = res_code_reg;
        res_slot     = CNT_W'(slot_reg);
        res_viewport = vp_reg;
        res_open     = 1'b1;
        case (res_code_reg)
            ST_FOUND:
            begin
                res_viewport = hit_vp_reg;
                res_open     = !hit_closed_reg;
            end
            ST_APPENDED, ST_RECLAIMED:
            begin
                res_viewport = vp_reg;
            end
            ST_SCRATCH:
            begin
                res_slot = CNT_W'(TABLE_DEPTH);
            end
            ST_UPDATED:
            begin
                res_viewport = (op_reg == OP_SET_VIEWPORT) ? vp_reg : hit_vp_reg;
                res_open     = (op_reg == OP_SET_OPEN) ? open_reg : !hit_closed_reg;
            end
            default:
            begin
                res_status   = ST_NOT_FOUND;
                res_slot     = '0;
                res_viewport = 8'd0;
            end
        endcase
    end

    ap_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("used count beyond table depth");

    ap_write_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (CNT_W'(slot_reg) < used_reg))
        else $error("table write outside the used entries");

    ap_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sel_append |=> (used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("append did not advance used count");

endmodule

`default_nettype wire

### rtl/window_record_table_evict_unit.sv
// Top level of the window record table: controller, datapath and output register.
// Depends on wrte_pkg, wrte_ctrl and wrte_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Keyed table of window records with least-recently-begun reclaiming. One transaction in,
// one result out. The entry memory has a single read port and is scanned one entry per
// cycle, so scan time grows with the used count: a rejected request (bad opcode, key zero
// on find/update) goes from decode straight to the response, a find or an update miss
// ends after the lookup scan, an update hit or an append also writes the table, and a get
// that has to reclaim runs a second scan over the used entries.
// The result waits in an output register, so the next transaction is taken while it is
// still pending. No clearing pass runs after reset; only appended entries are ever read.
// max_entries is written through cfg_wr_en/cfg_wr_data; 0 acts as 1 and values above
// TABLE_DEPTH act as TABLE_DEPTH.
module window_record_table_evict_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [CNT_W-1:0]    cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          opcode,
    input  wire logic [KEY_BITS-1:0] window_key,
    input  wire logic [31:0]         current_frame,
    input  wire logic [7:0]          viewport_index,
    input  wire logic                open_request,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CNT_W-1:0]         slot_index,
    output logic [2:0]               status,
    output logic [7:0]               entry_viewport,
    output logic                     is_open
);
    import wrte_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic             out_free;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] res_slot;
    logic [2:0]       res_status;
    logic [7:0]       res_viewport;
    logic             res_open;
    logic [CNT_W-1:0] slot_reg;
    logic [2:0]       status_reg;
    logic [7:0]       viewport_reg;
    logic             open_reg;

    wrte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrte_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .opcode         (opcode),
        .window_key     (window_key),
        .current_frame  (current_frame),
        .viewport_index (viewport_index),
        .open_request   (open_request),
        .cmd            (cmd),
        .stat           (stat),
        .res_slot       (res_slot),
        .res_status     (res_status),
        .res_viewport   (res_viewport),
        .res_open       (res_open)
    );

    // output register
    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.resp_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            slot_reg     <= res_slot;
            status_reg   <= res_status;
            viewport_reg <= res_viewport;
            open_reg     <= res_open;
        end
    end

    assign out_valid      = out_valid_reg;
    assign slot_index     = slot_reg;
    assign status         = status_reg;
    assign entry_viewport = viewport_reg;
    assign is_open        = open_reg;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for window_record_table_evict_unit: directed and random
// request streams, an in-bench predictor of the record table, and scoreboard checks.
// Depends on wrte_pkg and the RTL of window_record_table_evict_unit.
`timescale 1ns / 1ps

module tb;
    import wrte_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int          POOL_SIZE    = 96;
    localparam int          PHASES       = 6;
    localparam logic [6:0]  SCRATCH_SLOT = 7'd64;
    localparam logic [31:0] KEY_NONE     = 32'd0;
    // opcodes the block does not implement
    localparam logic [2:0]  OP_UNUSED_A  = 3'd5;
    localparam logic [2:0]  OP_UNUSED_B  = 3'd6;
    localparam logic [2:0]  OP_UNUSED_C  = 3'd7;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] frame;
        logic [7:0]  vp;
        logic        want_open;
    } req_t;

    typedef struct {
        logic [6:0] slot;
        logic [2:0] code;
        logic [7:0] vp;
        logic       open;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = OP_GET;
    logic [31:0] window_key = 32'd0;
    logic [31:0] current_frame = 32'd0;
    logic [7:0]  viewport_index = 8'd0;
    logic        open_request = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  slot_index;
    logic [2:0]  status;
    logic [7:0]  entry_viewport;
    logic        is_open;

    window_record_table_evict_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .window_key     (window_key),
        .current_frame  (current_frame),
        .viewport_index (viewport_index),
        .open_request   (open_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot_index     (slot_index),
        .status         (status),
        .entry_viewport (entry_viewport),
        .is_open        (is_open)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the record table
    logic [31:0] rec_key    [DEPTH];
    logic [31:0] rec_frame  [DEPTH];
    logic [7:0]  rec_vp     [DEPTH];
    logic        rec_closed [DEPTH];
    int          rec_used = 0;
    logic [6:0]  rec_limit = 7'd64;

    req_t        request_queue[$];
    reply_t      awaited_replies[$];
    req_t        next_req;
    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] cur_frame = 32'd0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          fault_count = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          status_hits [6] = '{default: 0};

    int          phase_limit [PHASES] = '{64, 4, 127, 1, 16, 40};
    idle_mode_t  phase_idle  [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                          IDLE_NONE, IDLE_BOTH};
    int          phase_items [PHASES] = '{150, 100, 110, 90, 100, 100};
    int          phase_get   [PHASES] = '{65, 45, 50, 45, 50, 55};
    int          phase_pool  [PHASES] = '{80, 24, 90, 40, 30, 96};
    logic [31:0] phase_frame [PHASES] = '{32'd100, 32'd5000, 32'd5200, 32'd70000,
                                          32'hFFFF_FFF0, 32'd12};

    // Works out the reply to one accepted request and updates the table copy.
    function automatic void table_predict(input req_t rq);
        reply_t r;
        int     hit;
        int     victim;
        int     lim;
        logic [31:0] oldest;
        hit = -1;
        for (int i = 0; i < rec_used; i++)
            if (hit < 0 && rec_key[i] == rq.key)
                hit = i;
        r.slot = 7'd0;
        r.code = ST_NOT_FOUND;
        r.vp   = 8'd0;
        r.open = 1'b1;
        if (rq.op == OP_GET)
        begin
            if (hit >= 0)
            begin
                r.slot = 7'(hit);
                r.code = ST_FOUND;
                r.vp   = rec_vp[hit];
                r.open = !rec_closed[hit];
            end
            else
            begin
                lim = (rec_limit == 0) ? 1 : (rec_limit > DEPTH) ? DEPTH : int'(rec_limit);
                victim = -1;
                if (rec_used < lim)
                begin
                    victim = rec_used;
                    rec_used++;
                    r.code = ST_APPENDED;
                end
                else
                begin
                    // oldest dormant entry; ties keep the first one
                    oldest = rq.frame;
                    for (int i = 0; i < rec_used; i++)
                        if (rec_frame[i] != rq.frame && rec_vp[i] == 8'd0 &&
                            (victim < 0 || rec_frame[i] < oldest))
                        begin
                            victim = i;
                            oldest = rec_frame[i];
                        end
                    r.code = ST_RECLAIMED;
                end
                if (victim < 0)
                begin
                    r.slot = SCRATCH_SLOT;
                    r.code = ST_SCRATCH;
                    r.vp   = rq.vp;
                end
                else
                begin
                    rec_key[victim]    = rq.key;
                    rec_vp[victim]     = rq.vp;
                    rec_frame[victim]  = 32'd0;
                    rec_closed[victim] = 1'b0;
                    r.slot = 7'(victim);
                    r.vp   = rq.vp;
                end
            end
        end
        else if (rq.op <= OP_SET_OPEN && rq.key != KEY_NONE && hit >= 0)
        begin
            case (rq.op)
                OP_MARK_BEGUN:   rec_frame[hit] = rq.frame;
                OP_SET_VIEWPORT: rec_vp[hit] = rq.vp;
                OP_SET_OPEN:     rec_closed[hit] = !rq.want_open;
                default:         ;
            endcase
            r.slot = 7'(hit);
            r.code = (rq.op == OP_FIND) ? ST_FOUND : ST_UPDATED;
            r.vp   = rec_vp[hit];
            r.open = !rec_closed[hit];
        end
        awaited_replies.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            fault_count++;
        end
    endfunction

    // driver: new transaction only once the current one has been taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = request_queue.pop_front();
                    in_valid       <= 1'b1;
                    opcode         <= next_req.op;
                    window_key     <= next_req.key;
                    current_frame  <= next_req.frame;
                    viewport_index <= next_req.vp;
                    open_request   <= next_req.want_open;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                rec_limit = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                n_results++;
                if (status < 3'd6)
                    status_hits[status]++;
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none got slot %0d status %0d",
                             $time, slot_index, status);
                    fault_count++;
                end
                else
                begin
                    check_field("slot_index", awaited_replies[0].slot, slot_index);
                    check_field("status", awaited_replies[0].code, status);
                    check_field("entry_viewport", awaited_replies[0].vp, entry_viewport);
                    check_field("is_open", awaited_replies[0].open, is_open);
                    void'(awaited_replies.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                n_accepted++;
                table_predict('{opcode, window_key, current_frame, viewport_index,
                                open_request});
            end
        end
    end

    task automatic queue_req(input logic [2:0] op, input logic [31:0] key,
                             input logic [31:0] frame, input logic [7:0] vp,
                             input logic want_open);
        request_queue.push_back('{op, key, frame, vp, want_open});
    endtask

    function automatic req_t make_request(input int get_pct, input int pool_n);
        req_t r;
        int   pick;
        if ($urandom_range(99) < 10)
            cur_frame = cur_frame + $urandom_range(1, 3);
        else if ($urandom_range(99) == 0)
            cur_frame = $urandom;
        r.frame = cur_frame;
        r.want_open = 1'($urandom_range(1));
        r.vp = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 88)
            r.key = key_pool[$urandom_range(pool_n - 1)];
        else if (pick < 95)
            r.key = $urandom;
        else
            r.key = KEY_NONE;
        if ($urandom_range(99) < get_pct)
        begin
            r.op = OP_GET;
            if ($urandom_range(99) < 55)
                r.vp = 8'd0;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 34)
                r.op = OP_FIND;
            else if (pick < 58)
            begin
                r.op = OP_MARK_BEGUN;
                // older begin frames give the reclaim scan something to order
                if ($urandom_range(99) < 40)
                    r.frame = cur_frame - $urandom_range(1, 6);
            end
            else if (pick < 78)
            begin
                r.op = OP_SET_VIEWPORT;
                if ($urandom_range(99) < 65)
                    r.vp = 8'd0;
            end
            else if (pick < 96)
                r.op = OP_SET_OPEN;
            else
                case ($urandom_range(2))
                    0:       r.op = OP_UNUSED_A;
                    1:       r.op = OP_UNUSED_B;
                    default: r.op = OP_UNUSED_C;
                endcase
        end
        return r;
    endfunction

    // waits until every transaction is taken and answered
    task automatic drain_all();
        while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic void set_idle(input idle_mode_t m);
        send_idle_pct  = (m == IDLE_SEND) ? 62 : (m == IDLE_BOTH) ? 32 : 0;
        recv_stall_pct = (m == IDLE_RECV) ? 62 : (m == IDLE_BOTH) ? 32 : 0;
    endfunction

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: reset limit, empty table, key zero, field extremes, bad opcodes
        queue_req(OP_FIND, 32'd5, 32'd10, 8'd0, 1'b0);
        queue_req(OP_GET, KEY_NONE, 32'd10, 8'd0, 1'b0);
        queue_req(OP_FIND, KEY_NONE, 32'd10, 8'd0, 1'b0);
        queue_req(OP_MARK_BEGUN, KEY_NONE, 32'd10, 8'd0, 1'b0);
        queue_req(OP_GET, KEY_NONE, 32'd10, 8'd9, 1'b0);
        queue_req(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        queue_req(OP_FIND, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0);
        queue_req(OP_SET_OPEN, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0);
        queue_req(OP_GET, 32'hFFFF_FFFF, 32'd0, 8'd3, 1'b0);
        queue_req(OP_SET_OPEN, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b1);
        queue_req(OP_SET_VIEWPORT, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0);
        queue_req(OP_MARK_BEGUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0);
        queue_req(OP_UNUSED_A, 32'hFFFF_FFFF, 32'd1, 8'd1, 1'b1);
        queue_req(OP_UNUSED_B, 32'hFFFF_FFFF, 32'd1, 8'd1, 1'b1);
        queue_req(OP_UNUSED_C, 32'hFFFF_FFFF, 32'd1, 8'd1, 1'b1);
        queue_req(OP_GET, 32'hA5A5_A5A5, 32'd7, 8'h5A, 1'b0);
        drain_all();

        // limit 0 acts as 1 and sits below the used count: reclaim, then nothing dormant
        write_limit(7'd0);
        queue_req(OP_GET, 32'h0000_1234, 32'hFFFF_FFFF, 8'h11, 1'b0);
        queue_req(OP_GET, 32'h0000_4321, 32'hFFFF_FFFF, 8'h07, 1'b0);
        queue_req(OP_FIND, 32'h0000_4321, 32'hFFFF_FFFF, 8'd0, 1'b0);
        queue_req(OP_SET_VIEWPORT, 32'hA5A5_A5A5, 32'd0, 8'd0, 1'b0);
        queue_req(OP_SET_VIEWPORT, 32'h0000_1234, 32'd0, 8'd0, 1'b0);
        queue_req(OP_MARK_BEGUN, 32'h0000_1234, 32'd3, 8'd0, 1'b0);
        queue_req(OP_GET, 32'h0000_0777, 32'd5, 8'd0, 1'b0);
        queue_req(OP_MARK_BEGUN, 32'h0000_1234, 32'd0, 8'd0, 1'b0);
        queue_req(OP_GET, 32'h0000_0999, 32'd5, 8'd0, 1'b0);
        drain_all();

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(7'(phase_limit[p]));
            set_idle(phase_idle[p]);
            cur_frame = phase_frame[p];
            for (int n = 0; n < phase_items[p]; n++)
            begin
                // sender holds off mid-phase until the table has answered everything
                if (n == phase_items[p] / 2)
                    drain_all();
                request_queue.push_back(make_request(phase_get[p], phase_pool[p]));
            end
            drain_all();
        end

        repeat (150) @(posedge clk);
        if (awaited_replies.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected more got none",
                     $time, awaited_replies.size());
            fault_count++;
        end
        $display("Covered %0d requests, %0d results, %0d limit settings, four idle patterns",
                 n_accepted, n_results, PHASES + 1);
        $display("found %0d appended %0d reclaimed %0d scratch %0d not found %0d updated %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
